[hw/rtl/b2da_pkg.sv]
`default_nettype none
package b2da_pkg;

  localparam int MAX_DIGITS   = 10;
  localparam int FIXED_DIGITS = 4;
  localparam int DIG_IDX_W    = $clog2(MAX_DIGITS);
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [6:0]  CHAR_ZERO   = 7'h30;
  localparam logic [6:0]  CHAR_MINUS  = 7'h2d;
  localparam logic [31:0] RECIP_TEN   = 32'hcccc_cccd;
  localparam int          RECIP_SHIFT = 35;

  localparam logic CMD_SIGNED = 1'b0;
  localparam logic CMD_FIXED4 = 1'b1;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic        cmd;
    logic        neg;
    logic [31:0] mag;
  } item_t;

endpackage
`default_nettype wire

[hw/rtl/b2da_if.sv]
`default_nettype none
interface b2da_in_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface b2da_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] ascii_char;
  logic       last;

  modport source (output valid, output ascii_char, output last, input ready);
  modport sink   (input valid, input ascii_char, input last, output ready);
endinterface
`default_nettype wire

[hw/rtl/b2da_front.sv]
`default_nettype none
module b2da_front (
  b2da_in_if.sink        in_ch,
  input  logic           q_full,
  output logic           q_push,
  output b2da_pkg::item_t q_item
);
  import b2da_pkg::*;

  logic [31:0] raw;
  logic        neg;

  assign raw = $unsigned(in_ch.value);
  assign neg = (in_ch.command == CMD_SIGNED) && raw[31];

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_item.cmd = in_ch.command;
    q_item.neg = neg;
    if (in_ch.command == CMD_FIXED4) begin
      q_item.mag = {16'h0000, raw[15:0]};
    end else if (neg) begin
      q_item.mag = (~raw) + 32'd1;
    end else begin
      q_item.mag = raw;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/b2da_queue.sv]
`default_nettype none
module b2da_queue #(
  parameter int DEPTH = b2da_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  b2da_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output b2da_pkg::item_t pop_item
);
  import b2da_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign valid    = (count_r != '0);
  assign pop_item = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("queue count did not rise on push");
  a_no_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid)
    else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

[hw/rtl/b2da_back.sv]
`default_nettype none
module b2da_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  b2da_pkg::item_t q_item,
  output logic            q_pop,
  b2da_out_if.source      out_ch
);
  import b2da_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_REM,
    S_SIGN,
    S_EMIT
  } state_t;

  state_t               state_r;
  logic                 cmd_r;
  logic                 neg_r;
  logic [31:0]          mag_r;
  logic [63:0]          prod_r;
  digit_t               dig_r [MAX_DIGITS];
  logic [DIG_IDX_W-1:0] n_r;
  logic [DIG_IDX_W-1:0] idx_r;
  logic                 out_valid_r;
  logic [6:0]           out_char_r;
  logic                 out_last_r;

  logic [31:0] quo;
  logic [31:0] quo_x10;
  logic [31:0] rem_full;
  digit_t      rem;
  logic        done;
  logic        slot_free;
  logic        emit_now;

  assign quo      = 32'(prod_r[63:RECIP_SHIFT]);
  assign quo_x10  = (quo << 3) + (quo << 1);
  assign rem_full = mag_r - quo_x10;
  assign rem      = rem_full[3:0];
  assign done     = (cmd_r == CMD_FIXED4) ? (n_r == DIG_IDX_W'(FIXED_DIGITS - 1))
                                          : (quo == '0);
  assign slot_free = !out_valid_r || out_ch.ready;
  assign emit_now  = slot_free && ((state_r == S_SIGN) || (state_r == S_EMIT));
  assign q_pop     = (state_r == S_IDLE) && q_valid;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.ascii_char = out_char_r;
  assign out_ch.last       = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_now) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r   <= q_item.cmd;
            neg_r   <= q_item.neg;
            mag_r   <= q_item.mag;
            n_r     <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= 64'(mag_r) * 64'(RECIP_TEN);
          state_r <= S_REM;
        end
        S_REM: begin
          dig_r[n_r] <= rem;
          mag_r      <= quo;
          if (done) begin
            idx_r   <= n_r;
            state_r <= neg_r ? S_SIGN : S_EMIT;
          end else begin
            n_r     <= n_r + DIG_IDX_W'(1);
            state_r <= S_MUL;
          end
        end
        S_SIGN: begin
          if (slot_free) begin
            out_char_r  <= CHAR_MINUS;
            out_last_r  <= 1'b0;
            state_r     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_char_r  <= CHAR_ZERO + {3'b000, dig_r[idx_r]};
            out_last_r  <= (idx_r == '0);
            if (idx_r == '0) begin
              state_r <= S_IDLE;
            end else begin
              idx_r <= idx_r - DIG_IDX_W'(1);
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REM) |-> (rem_full < 32'd10))
    else $error("remainder out of digit range");
  a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REM) |-> (n_r < DIG_IDX_W'(MAX_DIGITS)))
    else $error("digit count overflow");
  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && slot_free && idx_r == '0) |=>
      (state_r == S_IDLE && out_valid_r && out_last_r))
    else $error("final character not flagged");
`endif

endmodule
`default_nettype wire

[hw/rtl/binary_to_decimal_ascii.sv]
// binary to decimal ascii converter
// in_ch carries one word per value: command and a 32-bit value.
//   command 0: signed decimal, '-' for negatives, no leading zeros, '0' for zero
//   command 1: low 16 bits unsigned, exactly four digits of value mod 10000
// out_ch carries one character per word, last set on the final character.
// a front stage classifies the value (sign, magnitude) into a short queue;
// the back end extracts each digit with a reciprocal multiply by ten (a multiply
// state, then a quotient and remainder state), then emits the sign and
// the digits most significant first from a registered output slot.
// in_ch.ready stays high while the queue has room, so values are taken
// while the previous one is still converting.
// when the receiver stalls the output word holds and the back end waits;
// the queue keeps accepting until it is full.
// reset (rst_n low, synchronous) empties the queue and drops any partial run.
`default_nettype none
module binary_to_decimal_ascii #(
  parameter int QUEUE_DEPTH = b2da_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  b2da_in_if.sink     in_ch,
  b2da_out_if.source  out_ch
);
  import b2da_pkg::*;

  item_t push_item;
  item_t pop_item;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;

  b2da_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (push_item)
  );

  b2da_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (pop_item)
  );

  b2da_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (pop_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
`default_nettype wire
